// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the SHA-1 engine RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SHA1_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define SHA1_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== rtl/core/sha1_pkg.sv =====
// SHA-1 engine package: types, FSM states and algorithm constants.
// No dependencies; imported by sha1_rounds and sha1_hash_engine.
`timescale 1ns / 1ps

package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] hash_t;   // [0] = H0 / a

  // Initial chaining value, H0 at index 0
  localparam hash_t INIT_H = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                              32'hEFCDAB89, 32'h67452301};

  localparam word_t K_CH  = 32'h5A827999;
  localparam word_t K_PA1 = 32'h6ED9EBA1;
  localparam word_t K_MAJ = 32'h8F1BBCDC;
  localparam word_t K_PA2 = 32'hCA62C1D6;

  localparam logic [6:0] RND_PA1   = 7'd20;
  localparam logic [6:0] RND_MAJ   = 7'd40;
  localparam logic [6:0] RND_PA2   = 7'd60;
  localparam logic [6:0] RND_LAST  = 7'd79;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] PTR_LAST  = 6'd63;   // last byte of a block
  localparam logic [5:0] PTR_PRELEN = 6'd55;  // byte before the length field
  localparam logic [2:0] IDX_LAST  = 3'd4;

  typedef enum logic [2:0] {
    S_LOAD,     // taking message bytes
    S_PAD80,    // push the 0x80 marker
    S_PADZ,     // zero fill up to offset 56
    S_PADLEN,   // 64-bit bit length, big endian
    S_COMP,     // block compression running
    S_OUT       // digest words out
  } state_t;

  typedef struct packed {
    logic       load;    // shift one byte into the block window
    logic [7:0] data;
    logic       start;   // begin 80 rounds from the chaining value
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;          // one-cycle pulse, work vars final
  } core_stat_t;

endpackage

// ===== rtl/core/sha1_rounds.sv =====
// SHA-1 compression core: 512-bit block window / schedule and one round per cycle.
// Depends on sha1_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha1_rounds import sha1_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  core_ctl_t  ctl,
  input  hash_t      chain,
  output hash_t      work,
  output core_stat_t stat
);

  logic [511:0] window;   // word i at [511-32*i -: 32]; word 0 is next W
  hash_t        wv;
  hash_t        wv_next;
  logic [6:0]   rnd;
  logic         busy;
  logic         done;

  word_t a, b, c, d, e;
  word_t w, w_new, f, k, tmp, x;

  always_comb begin
    a = wv[0];
    b = wv[1];
    c = wv[2];
    d = wv[3];
    e = wv[4];
    w = window[511:480];
    // W[t+16] from W[t+13], W[t+8], W[t+2], W[t]
    x = window[95:64] ^ window[255:224] ^ window[447:416] ^ window[511:480];
    w_new = {x[30:0], x[31]};
    if (rnd < RND_PA1) begin
      f = (b & c) | (~b & d);
      k = K_CH;
    end else if (rnd < RND_MAJ) begin
      f = b ^ c ^ d;
      k = K_PA1;
    end else if (rnd < RND_PA2) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_MAJ;
    end else begin
      f = b ^ c ^ d;
      k = K_PA2;
    end
    tmp = {a[26:0], a[31:27]} + f + e + k + w;
    wv_next = {d, c, {b[1:0], b[31:2]}, a, tmp};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= busy && (rnd == RND_LAST);
      if (ctl.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        if (rnd == RND_LAST) begin
          busy <= 1'b0;
          rnd  <= '0;
        end else begin
          rnd <= rnd + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      window <= {window[503:0], ctl.data};
    end else if (busy) begin
      window <= {window[479:0], w_new};
    end
    if (ctl.start) begin
      wv <= chain;
    end else if (busy) begin
      wv <= wv_next;
    end
  end

  assign work      = wv;
  assign stat.busy = busy;
  assign stat.done = done;

  `SHA1_ASSERT(a_done_after_last, $fell(busy) |-> done, "round loop ended without done")
  `SHA1_NEVER(a_start_busy, ctl.start && busy, "start while rounds running")
  `SHA1_NEVER(a_load_busy, ctl.load && busy, "byte load corrupts schedule window")

endmodule

// ===== rtl/core/sha1_hash_engine.sv =====
// SHA-1 hash engine top level: byte intake, padding sequencer, chaining words
// and digest output. Depends on sha1_pkg, sha1_rounds and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Handshake                    Payload                Beat
// --------  ---------------------------  ---------------------  --------------------------
// byte in   byte_valid / byte_ready      kind, data_byte        one message byte or finish
// digest    digest_valid / digest_ready  digest_word, last_word one 32-bit word, H0 first
//
// The byte that completes a 64-byte block starts one compression in the
// shared round unit (one round per cycle); the result is then folded into the
// chaining words, and no byte is taken until that is done.
// A finish beat is followed by 9..72 pad/length bytes at one per cycle outside
// compressions, one or two compressions, then five digest beats at one per cycle
// while digest_ready is high.
// byte_ready is high only while the engine waits for message bytes.
// The digest words hold while digest_ready is low; nothing else advances then.
// Synchronous reset loads the initial chaining value and clears the length.

module sha1_hash_engine import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic        last_word
);

  state_t     state;
  state_t     state_next;
  state_t     resume;      // where to go when the running compression ends
  logic [60:0] len;        // message bytes; bit length is len * 8 mod 2^64
  logic [63:0] bit_len;    // length field, shifted out MSB byte first
  logic [2:0] idx;
  hash_t      chain;
  hash_t      work;
  core_ctl_t  ctl;
  core_stat_t cst;

  logic [5:0] ptr;
  logic       blk_end;
  logic       push;
  logic [7:0] push_data;
  logic       byte_take;
  logic       word_take;
  logic       msg_end;

  assign ptr       = len[5:0];
  assign blk_end   = (ptr == PTR_LAST);
  assign byte_take = byte_valid && byte_ready;
  assign word_take = digest_valid && digest_ready;
  assign msg_end   = word_take && (idx == IDX_LAST);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (byte_valid) begin
          if (kind) begin
            state_next = S_PAD80;
          end else if (blk_end) begin
            state_next = S_COMP;
          end
        end
      end
      S_PAD80, S_PADZ: begin
        if (blk_end) begin
          state_next = S_COMP;
        end else if (ptr == PTR_PRELEN) begin
          state_next = S_PADLEN;
        end else begin
          state_next = S_PADZ;
        end
      end
      S_PADLEN: begin
        if (blk_end) begin
          state_next = S_COMP;
        end
      end
      S_COMP: begin
        if (cst.done) begin
          state_next = resume;
        end
      end
      S_OUT: begin
        if (msg_end) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // outputs and byte source
  always_comb begin
    byte_ready   = 1'b0;
    digest_valid = 1'b0;
    push         = 1'b0;
    push_data    = '0;
    case (state)
      S_LOAD: begin
        byte_ready = 1'b1;
        push       = byte_valid && !kind;
        push_data  = data_byte;
      end
      S_PAD80: begin
        push      = 1'b1;
        push_data = PAD_BYTE;
      end
      S_PADZ: begin
        push = 1'b1;
      end
      S_PADLEN: begin
        push      = 1'b1;
        push_data = bit_len[63:56];
      end
      S_OUT: begin
        digest_valid = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
    ctl.load  = push;
    ctl.data  = push_data;
    ctl.start = push && blk_end;
  end

  assign digest_word = chain[idx];
  assign last_word   = (idx == IDX_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      resume <= S_LOAD;
      len    <= '0;
      idx    <= '0;
      chain  <= INIT_H;
    end else begin
      state <= state_next;
      if (ctl.start) begin
        if (state == S_LOAD) begin
          resume <= S_LOAD;
        end else if (state == S_PADLEN) begin
          resume <= S_OUT;
        end else begin
          resume <= S_PADZ;
        end
      end
      if (msg_end) begin
        len <= '0;
      end else if (push) begin
        len <= len + 61'd1;
      end
      if (word_take) begin
        idx <= (idx == IDX_LAST) ? 3'd0 : idx + 3'd1;
      end
      if (cst.done) begin
        for (int i = 0; i < 5; i++) begin
          chain[i] <= chain[i] + work[i];
        end
      end else if (msg_end) begin
        chain <= INIT_H;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take && kind) begin
      bit_len <= {len, 3'b000};
    end else if (state == S_PADLEN) begin
      bit_len <= {bit_len[55:0], 8'h00};
    end
  end

  sha1_rounds u_rounds (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .chain (chain),
    .work  (work),
    .stat  (cst)
  );

  `SHA1_NEVER(a_ready_busy, byte_ready && cst.busy, "byte intake open during compression")
  `SHA1_ASSERT(a_done_in_comp, cst.done |-> state == S_COMP, "compression done outside wait")
  `SHA1_ASSERT(a_next_msg, msg_end |=> byte_ready && len == 61'd0, "engine not reinitialized")

endmodule

// ===== test/sha1_digest_checker.sv =====
// Digest checker for the SHA-1 hash engine: byte-channel monitor, SHA-1
// predictor and digest-word scoreboard. Depends only on the port list of the block.
`timescale 1ns / 1ps

package sha1_tb_pkg;

  typedef enum logic {
    BEAT_DATA   = 1'b0,
    BEAT_FINISH = 1'b1
  } beat_kind_e;

endpackage

module sha1_digest_checker import sha1_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_ready,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic        digest_valid,
  input  logic        digest_ready,
  input  logic [31:0] digest_word,
  input  logic        last_word,
  output int          fail_count,
  output int          pending_words,
  output int          words_checked
);

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] RC_CHOOSE  = 32'h5A827999;
  localparam logic [31:0] RC_PARITY1 = 32'h6ED9EBA1;
  localparam logic [31:0] RC_MAJOR   = 32'h8F1BBCDC;
  localparam logic [31:0] RC_PARITY2 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  logic [31:0]  chain [5];
  logic [7:0]   blk_buf [64];
  logic [63:0]  msg_len;
  digest_beat_t expected_words [$];

  function automatic void load_iv();
    chain[0] = IV0;
    chain[1] = IV1;
    chain[2] = IV2;
    chain[3] = IV3;
    chain[4] = IV4;
    msg_len  = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, tmp, mix;
    int t;
    for (t = 0; t < 16; t++)
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (t = 0; t < 80; t++) begin
      if (t >= 16) begin
        mix = w[(t+13) & 15] ^ w[(t+8) & 15] ^ w[(t+2) & 15] ^ w[t & 15];
        w[t & 15] = {mix[30:0], mix[31]};
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = RC_CHOOSE;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = RC_PARITY1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RC_MAJOR;
      end else begin
        f = b ^ c ^ d;
        k = RC_PARITY2;
      end
      tmp = {a[26:0], a[31:27]} + f + e + k + w[t & 15];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
    chain[4] = chain[4] + e;
  endfunction

  function automatic void absorb_byte(logic [7:0] v);
    blk_buf[msg_len[5:0]] = v;
    msg_len = msg_len + 64'd1;
    if (msg_len[5:0] == 6'd0)
      compress_block();
  endfunction

  // pad, append bit length, queue the five digest words, restart
  function automatic void close_message();
    logic [63:0]  bit_len;
    digest_beat_t beat;
    int i;
    bit_len = msg_len << 3;
    absorb_byte(PAD_MARK);
    while (msg_len[5:0] != LEN_OFFSET)
      absorb_byte(8'h00);
    for (i = 7; i >= 0; i--)
      absorb_byte(bit_len[8*i +: 8]);
    for (i = 0; i < 5; i++) begin
      beat.word = chain[i];
      beat.last = (i == 4);
      expected_words.push_back(beat);
    end
    load_iv();
  endfunction

  always @(posedge clk) begin
    digest_beat_t want;
    if (rst) begin
      expected_words.delete();
      load_iv();
      fail_count    = 0;
      words_checked = 0;
    end else begin
      if (digest_valid && digest_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected digest beat: expected none, actual word %h last %b",
                   $time, digest_word, last_word);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (digest_word !== want.word) begin
            $display("%0t: digest_word mismatch: expected %h, actual %h",
                     $time, want.word, digest_word);
            fail_count++;
          end
          if (last_word !== want.last) begin
            $display("%0t: last_word mismatch: expected %b, actual %b",
                     $time, want.last, last_word);
            fail_count++;
          end
        end
      end
      if (byte_valid && byte_ready) begin
        if (kind == BEAT_FINISH)
          close_message();
        else
          absorb_byte(data_byte);
      end
    end
    pending_words = expected_words.size();
  end

endmodule

// ===== test/tb_sha1_hash_engine.sv =====
// Testbench top for sha1_hash_engine: clock, reset, byte stimulus, digest
// back-pressure and verdict. Depends on sha1_pkg (via the block) and sha1_digest_checker.sv.
`timescale 1ns / 1ps

module tb_sha1_hash_engine import sha1_tb_pkg::*;;

  localparam int ITEM_TARGET  = 410;
  localparam int CYCLE_LIMIT  = 1000000; // room for all-finish beats at longest stalls
  localparam int DRAIN_CYCLES = 300;     // > two compressions plus padding
  localparam int MAX_IDLE     = 18;

  logic        clk;
  logic        rst          = 1'b1;
  logic        byte_valid   = 1'b0;
  logic        kind         = BEAT_DATA;
  logic [7:0]  data_byte    = 8'h00;
  logic        digest_ready = 1'b0;
  logic        byte_ready;
  logic        digest_valid;
  logic [31:0] digest_word;
  logic        last_word;

  int fail_count;
  int pending_words;
  int words_checked;
  int cycle_count;

  // stimulus bookkeeping, used for the end-of-run summary
  int items_sent;
  int msgs_sent;
  int bytes_sent;
  int cur_len;
  int longest_msg;
  bit byte_calm;   // when set, the byte side sends back to back

  // Lengths around the padding boundaries: 55 and 119 pad into one block, 56,
  // 63 and 120 force a second pad block, 64 ends exactly on a block border.
  int edge_lens [6] = '{55, 56, 63, 64, 119, 120};

  sha1_hash_engine dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_word  (digest_word),
    .last_word    (last_word)
  );

  sha1_digest_checker u_digest_chk (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .kind          (kind),
    .data_byte     (data_byte),
    .digest_valid  (digest_valid),
    .digest_ready  (digest_ready),
    .digest_word   (digest_word),
    .last_word     (last_word),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d digest words still expected",
             cycle_count, pending_words);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // One byte-channel beat. Called at a falling edge, returns at the falling
  // edge after acceptance. With no gap, valid simply stays high into the
  // next beat so it is never dropped and raised in the same step.
  task automatic send_beat(input beat_kind_e k, input logic [7:0] b);
    int gap;
    gap = byte_calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    kind       <= k;
    data_byte  <= b;
    do @(posedge clk); while (!byte_ready);
    @(negedge clk);
    items_sent++;
    if (k == BEAT_FINISH) begin
      msgs_sent++;
      if (cur_len > longest_msg)
        longest_msg = cur_len;
      cur_len = 0;
    end else begin
      bytes_sent++;
      cur_len++;
    end
  endtask

  // A message of random bytes, closed by a finish beat whose byte is noise.
  task automatic send_message(input int len);
    int i;
    byte_calm = ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++)
      send_beat(BEAT_DATA, 8'($urandom_range(0, 255)));
    send_beat(BEAT_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // Digest side: per beat, hold ready low for a random stall once a word is
  // offered; every fifth beat decides whether the next run of beats is stall-free.
  initial begin
    int stall;
    int beats;
    bit ready_calm;
    beats      = 0;
    ready_calm = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (beats % 5 == 0)
        ready_calm = ($urandom_range(0, 3) == 0);
      stall = ready_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        digest_ready <= 1'b0;
        while (!digest_valid) @(negedge clk);
        repeat (stall) @(negedge clk);
      end
      digest_ready <= 1'b1;
      do @(posedge clk); while (!digest_valid);
      @(negedge clk);
      beats++;
    end
  end

  initial begin
    int pick;
    items_sent  = 0;
    msgs_sent   = 0;
    bytes_sent  = 0;
    cur_len     = 0;
    longest_msg = 0;
    byte_calm   = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty message with a nonzero (ignored) finish byte.
    send_beat(BEAT_FINISH, 8'hFF);
    // Single zero byte.
    send_beat(BEAT_DATA, 8'h00);
    send_beat(BEAT_FINISH, 8'h00);
    // "abc", the textbook vector.
    send_beat(BEAT_DATA, 8'h61);
    send_beat(BEAT_DATA, 8'h62);
    send_beat(BEAT_DATA, 8'h63);
    send_beat(BEAT_FINISH, 8'h5A);
    // Byte extremes and alternating bit patterns, back to back.
    byte_calm = 1'b1;
    send_beat(BEAT_DATA, 8'hFF);
    send_beat(BEAT_DATA, 8'h80);
    send_beat(BEAT_DATA, 8'h7F);
    send_beat(BEAT_DATA, 8'h01);
    send_beat(BEAT_DATA, 8'hAA);
    send_beat(BEAT_DATA, 8'h55);
    send_beat(BEAT_FINISH, 8'h80);
    // An empty message right after another message: engine must reinitialize cleanly.
    send_beat(BEAT_FINISH, 8'h01);

    // Random messages: mostly short, some on the padding boundaries, a few empty.
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 2)
        send_message(edge_lens[$urandom_range(0, 5)]);
      else if (pick == 2)
        send_message(0);
      else
        send_message($urandom_range(1, 24));
    end
    byte_valid <= 1'b0;

    // Let the last digest drain, then give the engine time to show any stray beat.
    while (pending_words != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d beats: %0d messages, %0d data bytes, longest %0d bytes",
             items_sent, msgs_sent, bytes_sent, longest_msg);
    $display("Checked %0d digest words under random byte gaps and digest stalls",
             words_checked);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
